>>> src/wsts_pkg.sv
`default_nettype none
package wsts_pkg;
    localparam int WORKERS      = 4;
    localparam int NDEQ         = WORKERS + 1;
    localparam int DEQUE_DEPTH  = 256;
    localparam int GLOBAL_DEPTH = 256;
    localparam int DQ_AW = $clog2(DEQUE_DEPTH);
    localparam int DQ_PW = DQ_AW + 1;
    localparam int GL_AW = $clog2(GLOBAL_DEPTH);
    localparam int GL_CW = GL_AW + 1;
    localparam int DQ_IW = $clog2(NDEQ);
    localparam int WK_IW = $clog2(WORKERS);

    localparam logic [1:0] ACT_SUBMIT = 2'd0;
    localparam logic [1:0] ACT_TARGET = 2'd1;
    localparam logic [1:0] ACT_FETCH  = 2'd2;

    localparam logic [2:0] ST_LOCAL  = 3'd0;
    localparam logic [2:0] ST_GLOBAL = 3'd1;
    localparam logic [2:0] ST_DROP   = 3'd2;
    localparam logic [2:0] ST_GIVEN  = 3'd3;
    localparam logic [2:0] ST_NONE   = 3'd4;

    localparam logic [1:0] SRC_OWN    = 2'd0;
    localparam logic [1:0] SRC_GLOBAL = 2'd1;
    localparam logic [1:0] SRC_STOLEN = 2'd2;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_DONE} state_t;

    // memory request from the controller
    typedef struct packed {
        logic             dq_we;
        logic             dq_re;
        logic [DQ_IW-1:0] dq_sel;
        logic [DQ_AW-1:0] dq_addr;
        logic             gl_we;
        logic             gl_re;
        logic [GL_AW-1:0] gl_addr;
        logic [15:0]      wdata;
    } mem_req_t;
endpackage
`default_nettype wire

>>> src/wsts_mem.sv
`default_nettype none
module wsts_mem (
    input  wire logic               clk,
    input  wire wsts_pkg::mem_req_t req,
    output logic [15:0]             dq_rdata,
    output logic [15:0]             gl_rdata
);
    localparam int DQ_W = wsts_pkg::DQ_IW + wsts_pkg::DQ_AW;
    logic [15:0] dq_mem [wsts_pkg::NDEQ*wsts_pkg::DEQUE_DEPTH];
    logic [15:0] gl_mem [wsts_pkg::GLOBAL_DEPTH];
    logic [DQ_W-1:0] dq_a;

    assign dq_a = {req.dq_sel, req.dq_addr};

    always_ff @(posedge clk)
    begin
        if (req.dq_we)
            dq_mem[dq_a] <= req.wdata;
        if (req.dq_re)
            dq_rdata <= dq_mem[dq_a];
    end

    always_ff @(posedge clk)
    begin
        if (req.gl_we)
            gl_mem[req.gl_addr] <= req.wdata;
        if (req.gl_re)
            gl_rdata <= gl_mem[req.gl_addr];
    end
endmodule
`default_nettype wire

>>> src/work_stealing_task_scheduler.sv
`default_nettype none
// Work-stealing task scheduler. An item is taken when start is high and busy
// low; the block then steps through S_READ to S_DONE, where the result is shown
// for one cycle with done high, and busy stays high until then, so no new item
// is taken before the last one is through. Pointer, count and sleep state sit
// in flip-flops and all decisions are made in the accept cycle; the single read
// of a deque or global store entry, through the synchronous memory port, sets
// the latency. The result cannot be stalled: it must be taken in the cycle done
// is high.
module work_stealing_task_scheduler (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  action,
    input  wire logic [2:0]  worker,
    input  wire logic [15:0] task_req,
    output logic             done,
    output logic [2:0]       status,
    output logic [15:0]      task_out,
    output logic [1:0]       source,
    output logic [1:0]       victim,
    output logic             woke_valid,
    output logic [2:0]       woke_worker
);
    localparam int NDEQ = wsts_pkg::NDEQ;
    localparam int PW   = wsts_pkg::DQ_PW;
    localparam int CW   = wsts_pkg::GL_CW;
    localparam int AW   = wsts_pkg::GL_AW;

    wsts_pkg::state_t state_reg, state_next;
    logic [PW-1:0] newest_reg [NDEQ];
    logic [PW-1:0] newest_next [NDEQ];
    logic [PW-1:0] oldest_reg [NDEQ];
    logic [PW-1:0] oldest_next [NDEQ];
    logic [AW-1:0] rd_reg, rd_next, wr_reg, wr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NDEQ-1:0] sleep_reg, sleep_next;

    logic [2:0]  status_reg, status_next;
    logic [1:0]  source_reg, source_next, victim_reg, victim_next;
    logic        wv_reg, wv_next;
    logic [2:0]  ww_reg, ww_next;
    logic        fromdq_reg, fromdq_next;

    wsts_pkg::mem_req_t req;
    logic [15:0] dq_rdata, gl_rdata;

    wsts_mem u_mem (
        .clk      (clk),
        .req      (req),
        .dq_rdata (dq_rdata),
        .gl_rdata (gl_rdata)
    );

    logic [NDEQ-1:0] dq_empty, dq_full;
    always_comb
    begin
        for (int d = 0; d < NDEQ; d++)
        begin
            dq_empty[d] = newest_reg[d] == oldest_reg[d];
            dq_full[d]  = (newest_reg[d] - oldest_reg[d]) == PW'(wsts_pkg::DEQUE_DEPTH);
        end
    end

    always_comb
    begin
        logic is_w, is_dq, push_gl, found, wake_any;
        logic [wsts_pkg::DQ_IW-1:0] wi;
        logic [PW-1:0] np;
        state_next = state_reg;
        for (int d = 0; d < NDEQ; d++)
        begin
            newest_next[d] = newest_reg[d];
            oldest_next[d] = oldest_reg[d];
        end
        rd_next = rd_reg; wr_next = wr_reg; cnt_next = cnt_reg;
        sleep_next = sleep_reg;
        status_next = status_reg; source_next = source_reg; victim_next = victim_reg;
        wv_next = wv_reg; ww_next = ww_reg; fromdq_next = fromdq_reg;
        req = '0;
        req.wdata = task_req;
        is_w = worker < 3'(wsts_pkg::WORKERS);
        is_dq = worker <= 3'(wsts_pkg::WORKERS);
        wi = wsts_pkg::DQ_IW'(worker);
        push_gl = 1'b0; found = 1'b0; wake_any = 1'b0; np = '0;
        busy = state_reg != wsts_pkg::S_IDLE;
        done = state_reg == wsts_pkg::S_DONE;
        case (state_reg)
            wsts_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = wsts_pkg::S_READ;
                    status_next = wsts_pkg::ST_NONE;
                    source_next = wsts_pkg::SRC_OWN; victim_next = '0;
                    wv_next = 1'b0; ww_next = '0; fromdq_next = 1'b0;
                    if (action == wsts_pkg::ACT_TARGET && is_dq)
                    begin
                        if (dq_full[wi])
                            status_next = wsts_pkg::ST_DROP;
                        else
                        begin
                            status_next = wsts_pkg::ST_LOCAL;
                            req.dq_we = 1'b1; req.dq_sel = wi;
                            req.dq_addr = newest_reg[wi][PW-2:0];
                            newest_next[wi] = newest_reg[wi] + 1'b1;
                        end
                        if (sleep_reg[wi])
                        begin
                            sleep_next[wi] = 1'b0; wv_next = 1'b1; ww_next = worker;
                        end
                    end
                    else if (action == wsts_pkg::ACT_SUBMIT || action == wsts_pkg::ACT_TARGET)
                    begin
                        if (action == wsts_pkg::ACT_SUBMIT && is_w && !dq_full[wi])
                        begin
                            status_next = wsts_pkg::ST_LOCAL;
                            req.dq_we = 1'b1; req.dq_sel = wi;
                            req.dq_addr = newest_reg[wi][PW-2:0];
                            newest_next[wi] = newest_reg[wi] + 1'b1;
                        end
                        else
                            push_gl = 1'b1;
                        if (push_gl)
                        begin
                            if (cnt_reg == CW'(wsts_pkg::GLOBAL_DEPTH))
                                status_next = wsts_pkg::ST_DROP;
                            else
                            begin
                                status_next = wsts_pkg::ST_GLOBAL;
                                req.gl_we = 1'b1; req.gl_addr = wr_reg;
                                wr_next = wr_reg + 1'b1; cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        for (int i = 0; i < wsts_pkg::WORKERS; i++)
                        begin
                            if (!wake_any && sleep_reg[i])
                            begin
                                wake_any = 1'b1; sleep_next[i] = 1'b0;
                                wv_next = 1'b1; ww_next = 3'(i);
                            end
                        end
                    end
                    else if (action == wsts_pkg::ACT_FETCH && is_dq)
                    begin
                        if (!dq_empty[wi])
                        begin
                            np = newest_reg[wi] - 1'b1;
                            newest_next[wi] = np;
                            req.dq_re = 1'b1; req.dq_sel = wi; req.dq_addr = np[PW-2:0];
                            status_next = wsts_pkg::ST_GIVEN; fromdq_next = 1'b1;
                            source_next = wsts_pkg::SRC_OWN;
                        end
                        else if (cnt_reg != '0)
                        begin
                            req.gl_re = 1'b1; req.gl_addr = rd_reg;
                            rd_next = rd_reg + 1'b1; cnt_next = cnt_reg - 1'b1;
                            status_next = wsts_pkg::ST_GIVEN;
                            source_next = wsts_pkg::SRC_GLOBAL;
                        end
                        else if (is_w)
                        begin
                            for (int i = 0; i < wsts_pkg::WORKERS; i++)
                            begin
                                if (!found && 3'(i) != worker && !dq_empty[i])
                                begin
                                    found = 1'b1;
                                    req.dq_re = 1'b1;
                                    req.dq_sel = wsts_pkg::DQ_IW'(i);
                                    req.dq_addr = oldest_reg[i][PW-2:0];
                                    oldest_next[i] = oldest_reg[i] + 1'b1;
                                    status_next = wsts_pkg::ST_GIVEN; fromdq_next = 1'b1;
                                    source_next = wsts_pkg::SRC_STOLEN;
                                    victim_next = 2'(i);
                                end
                            end
                        end
                        if (status_next != wsts_pkg::ST_GIVEN)
                            sleep_next[wi] = 1'b1;
                    end
                end
            end
            wsts_pkg::S_READ: state_next = wsts_pkg::S_DONE;
            wsts_pkg::S_DONE: state_next = wsts_pkg::S_IDLE;
            default: state_next = wsts_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wsts_pkg::S_IDLE;
            for (int d = 0; d < NDEQ; d++)
            begin
                newest_reg[d] <= '0;
                oldest_reg[d] <= '0;
            end
            rd_reg <= '0; wr_reg <= '0; cnt_reg <= '0; sleep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            for (int d = 0; d < NDEQ; d++)
            begin
                newest_reg[d] <= newest_next[d];
                oldest_reg[d] <= oldest_next[d];
            end
            rd_reg <= rd_next; wr_reg <= wr_next; cnt_reg <= cnt_next;
            sleep_reg <= sleep_next;
        end
    end

    logic [15:0] task_reg;
    always_ff @(posedge clk)
    begin
        status_reg <= status_next; source_reg <= source_next;
        victim_reg <= victim_next; wv_reg <= wv_next; ww_reg <= ww_next;
        fromdq_reg <= fromdq_next;
        if (state_reg == wsts_pkg::S_READ)
            task_reg <= (status_reg != wsts_pkg::ST_GIVEN) ? 16'd0
                      : (fromdq_reg ? dq_rdata : gl_rdata);
    end

    assign status = status_reg;
    assign task_out = task_reg;
    assign source = source_reg;
    assign victim = victim_reg;
    assign woke_valid = wv_reg;
    assign woke_worker = ww_reg;

`ifndef ASSERT_OFF
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(wsts_pkg::GLOBAL_DEPTH)) else $error("global count overflow");
    a_done_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == wsts_pkg::S_READ) else $error("done out of sequence");
    a_woke_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !woke_valid |-> woke_worker == 3'd0) else $error("stray woken index");
`endif
endmodule
`default_nettype wire

>>> verif/sched_checker.sv
module sched_checker
    import wsts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [1:0]  action,
    input  wire logic [2:0]  worker,
    input  wire logic [15:0] task_req,
    input  wire logic        done,
    input  wire logic [2:0]  status,
    input  wire logic [15:0] task_out,
    input  wire logic [1:0]  source,
    input  wire logic [1:0]  victim,
    input  wire logic        woke_valid,
    input  wire logic [2:0]  woke_worker,
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] task_out;
        logic [1:0]  source;
        logic [1:0]  victim;
        logic        woke_valid;
        logic [2:0]  woke_worker;
    } outcome_t;

    logic [15:0] dq_mem [NDEQ][DEQUE_DEPTH];
    int          dq_head [NDEQ];
    int          dq_tail [NDEQ];
    logic [15:0] gl_mem [GLOBAL_DEPTH];
    int          gl_rd, gl_wr, gl_cnt;
    logic [NDEQ-1:0] asleep;
    outcome_t    outcomes [$];

    assign pending = outcomes.size();

    function automatic int dq_fill(int d);
        return (dq_head[d] - dq_tail[d] + 2 * DEQUE_DEPTH) % (2 * DEQUE_DEPTH);
    endfunction

    function automatic bit dq_push(int d, logic [15:0] t);
        if (dq_fill(d) >= DEQUE_DEPTH)
            return 0;
        dq_mem[d][dq_head[d] % DEQUE_DEPTH] = t;
        dq_head[d] = (dq_head[d] + 1) % (2 * DEQUE_DEPTH);
        return 1;
    endfunction

    function automatic bit gl_push(logic [15:0] t);
        if (gl_cnt >= GLOBAL_DEPTH)
            return 0;
        gl_mem[gl_wr] = t;
        gl_wr = (gl_wr + 1) % GLOBAL_DEPTH;
        gl_cnt++;
        return 1;
    endfunction

    function automatic outcome_t schedule(logic [1:0] act, logic [2:0] who,
                                          logic [15:0] t);
        outcome_t o;
        o = '0;
        o.status = ST_NONE;
        if (act == ACT_TARGET && who <= WORKERS) begin
            o.status = dq_push(who, t) ? ST_LOCAL : ST_DROP;
            if (asleep[who]) begin
                asleep[who] = 0;
                o.woke_valid = 1;
                o.woke_worker = who;
            end
        end else if (act == ACT_SUBMIT || act == ACT_TARGET) begin
            if (act == ACT_SUBMIT && who < WORKERS && dq_push(who, t))
                o.status = ST_LOCAL;
            else
                o.status = gl_push(t) ? ST_GLOBAL : ST_DROP;
            for (int i = 0; i < WORKERS; i++) begin
                if (asleep[i]) begin
                    asleep[i] = 0;
                    o.woke_valid = 1;
                    o.woke_worker = 3'(i);
                    break;
                end
            end
        end else if (act == ACT_FETCH && who <= WORKERS) begin
            if (dq_fill(who) != 0) begin
                dq_head[who] = (dq_head[who] + 2 * DEQUE_DEPTH - 1) % (2 * DEQUE_DEPTH);
                o.task_out = dq_mem[who][dq_head[who] % DEQUE_DEPTH];
                o.status = ST_GIVEN;
                o.source = SRC_OWN;
            end else if (gl_cnt != 0) begin
                o.task_out = gl_mem[gl_rd];
                gl_rd = (gl_rd + 1) % GLOBAL_DEPTH;
                gl_cnt--;
                o.status = ST_GIVEN;
                o.source = SRC_GLOBAL;
            end else if (who < WORKERS) begin
                for (int i = 0; i < WORKERS; i++) begin
                    if (i != who && dq_fill(i) != 0) begin
                        o.task_out = dq_mem[i][dq_tail[i] % DEQUE_DEPTH];
                        dq_tail[i] = (dq_tail[i] + 1) % (2 * DEQUE_DEPTH);
                        o.status = ST_GIVEN;
                        o.source = SRC_STOLEN;
                        o.victim = 2'(i);
                        break;
                    end
                end
            end
            if (o.status != ST_GIVEN)
                asleep[who] = 1;
        end
        return o;
    endfunction

    outcome_t seen, want;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int d = 0; d < NDEQ; d++) begin
                dq_head[d] = 0;
                dq_tail[d] = 0;
            end
            gl_rd = 0;
            gl_wr = 0;
            gl_cnt = 0;
            asleep = '0;
            outcomes.delete();
            fail_count = 0;
        end else begin
            // check result before queueing this edge's item
            if (done) begin
                seen = {status, task_out, source, victim, woke_valid, woke_worker};
                if (outcomes.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %h", seen);
                end else begin
                    want = outcomes.pop_front();
                    if (seen !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: st %0d/%0d task %h/%h src %0d/%0d ",
                                     want.status, status, want.task_out, task_out,
                                     want.source, source,
                                     "vic %0d/%0d wv %0d/%0d ww %0d/%0d",
                                     want.victim, victim,
                                     want.woke_valid, woke_valid, want.woke_worker,
                                     woke_worker);
                    end
                end
            end
            if (start && !busy)
                outcomes.push_back(schedule(action, worker, task_req));
        end
    end
endmodule

>>> verif/testbench.sv
module testbench;
    import wsts_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // action code with no meaning to the block
    localparam logic [1:0] ACT_SPARE = 2'd3;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        start = 0;
    logic [1:0]  action = ACT_SUBMIT;
    logic [2:0]  worker = '0;
    logic [15:0] task_req = '0;
    wire         busy, done, woke_valid;
    wire [2:0]   status, woke_worker;
    wire [15:0]  task_out;
    wire [1:0]   source, victim;
    int          fail_count, pending;
    int          cycles = 0;
    bit          no_gaps = 0;

    always #4 clk = ~clk;

    work_stealing_task_scheduler dut (.*);
    sched_checker checker_i (.*);

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 200000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // start stays high between items sent back to back
    task automatic issue(logic [1:0] a, logic [2:0] w, logic [15:0] t);
        if (!no_gaps && $urandom_range(0, 5) == 0) begin
            start <= 0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        start <= 1;
        action <= a;
        worker <= w;
        task_req <= t;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    initial begin
        int r;
        logic [1:0] a;
        repeat (5) @(negedge clk);
        rst_n = 1;
        // directed: extremes, every action, sleep/wake, steals, externals
        issue(ACT_FETCH, 3'd0, 16'h0);
        issue(ACT_FETCH, 3'd4, 16'h0);
        issue(ACT_FETCH, 3'd5, 16'h0);
        issue(ACT_SUBMIT, 3'd5, 16'hFFFF);
        issue(ACT_TARGET, 3'd4, 16'h1234);
        issue(ACT_FETCH, 3'd4, 16'h0);
        issue(ACT_SUBMIT, 3'd1, 16'hAAAA);
        issue(ACT_SUBMIT, 3'd1, 16'h5555);
        issue(ACT_FETCH, 3'd2, 16'h0);
        issue(ACT_FETCH, 3'd1, 16'h0);
        issue(ACT_FETCH, 3'd3, 16'h0);
        issue(ACT_TARGET, 3'd3, 16'h0001);
        issue(ACT_TARGET, 3'd5, 16'h8000);
        issue(ACT_TARGET, 3'd7, 16'h00FF);
        issue(ACT_SPARE, 3'd6, 16'hFF00);
        issue(ACT_FETCH, 3'd7, 16'h0);
        issue(ACT_SUBMIT, 3'd4, 16'h7777);
        issue(ACT_FETCH, 3'd0, 16'h0);
        // fill worker 0 to overflow into global, then global to drops
        for (int i = 0; i < 520; i++)
            issue(ACT_SUBMIT, 3'd0, 16'($urandom));
        issue(ACT_TARGET, 3'd0, 16'hBEEF);
        for (int i = 0; i < 240; i++)
            issue(ACT_FETCH, 3'($urandom_range(0, 4)), 16'h0);
        for (int i = 0; i < 340; i++) begin
            if (i > 270)
                no_gaps = 1;
            r = $urandom_range(0, 99);
            a = r < 40 ? ACT_SUBMIT : r < 55 ? ACT_TARGET : r < 97 ? ACT_FETCH : ACT_SPARE;
            issue(a, 3'($urandom_range(0, 7)), 16'($urandom));
        end
        start <= 0;
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
